>>> hw/rtl/hrfc_pkg.sv
// Shared constants and coefficient tables for the hall row force calibration.
// No dependencies; hrfc_poly, hrfc_lane and the top level import this package.
package hrfc_pkg;

  // Row shape and field widths
  localparam int N_POS   = 3;
  localparam int N_TERM  = 9;
  localparam int IN_FW   = 17;
  localparam int FORCE_W = 24;
  localparam int FR_W    = 23;
  localparam int IN_TDATA_W  = 160;
  localparam int OUT_TDATA_W = 288;
  localparam int POS_IN_W  = 3 * IN_FW;
  localparam int POS_OUT_W = 3 * FORCE_W + FR_W;

  // Monomial, product and accumulator widths
  localparam int W_W      = 60;
  localparam int LO_W     = 30;
  localparam int HP_W     = 46;
  localparam int P_W      = 75;
  localparam int ACC_W    = 88;
  localparam int HORNER_N = 15;
  localparam int Q_W      = 24;
  localparam int REM_W    = 62;
  localparam int DIV_SHIFT = 24;

  // Reciprocal divide by 5^16: estimate, multiply back, correct by one
  localparam int DIV_N     = 4;
  localparam int MH_LO     = 29;
  localparam int MH_W      = REM_W - MH_LO;
  localparam int RCP_W     = 28;
  localparam int RCP_SHIFT = 36;
  localparam int QP_W      = MH_W + RCP_W;

  // Divisor 1e16 * 2^8 = 2^24 * 5^16
  localparam logic [63:0] DIV5     = 64'd152587890625;
  localparam logic [63:0] DIV_HALF = 64'd1280000000000000000;
  localparam logic [63:0] SAT_POS  = DIV5 * 64'd8388608;
  localparam logic [63:0] SAT_NEG  = DIV5 * 64'd8388609;

  // floor(2^65 / 5^16); the estimate it gives is the quotient or one less
  localparam logic [RCP_W-1:0] RCP = 28'd241785163;

  localparam logic [FORCE_W-1:0] FORCE_MAX = 24'h7FFFFF;
  localparam logic [FORCE_W-1:0] FORCE_MIN = 24'h800000;
  localparam logic [FR_W-1:0]    FR_MAX    = 23'h7FFFFF;

  localparam logic signed [W_W-1:0] W_ONE = 60'sd256;

  // Square root units
  localparam int R_IN_W = 50;
  localparam int R_RW   = 25;
  localparam int F_IN_W = 48;
  localparam int F_RW   = 24;

  localparam int POLY_LAT = 2 + HORNER_N + 2 + DIV_N + 1;
  localparam int LANE_LAT = R_RW + 3 + POLY_LAT + F_RW + 3;

  // Coefficient mantissas, per row: 1, a, z, a^2, a*z, z^2, a^2*z, a*z^2, z^3
  localparam logic signed [14:0] MANT [9][9] = '{
    '{15'sd1333, -15'sd3288, 15'sd3361, 15'sd724, -15'sd6201, 15'sd2654,
      15'sd4886, -15'sd242, 15'sd6595},
    '{15'sd2824, -15'sd4832, 15'sd1006, 15'sd521, -15'sd3988, 15'sd135,
      15'sd3199, -15'sd218, 15'sd4829},
    '{15'sd2447, -15'sd4608, 15'sd6606, 15'sd3998, -15'sd6645, 15'sd5293,
      15'sd6865, -15'sd2459, 15'sd106},
    '{15'sd1411, -15'sd2827, 15'sd3494, 15'sd1662, -15'sd1945, 15'sd3569,
      15'sd112, -15'sd9128, 15'sd1119},
    '{15'sd7812, -15'sd4493, 15'sd2601, -15'sd1078, -15'sd7358, 15'sd2632,
      -15'sd1189, -15'sd2614, 15'sd7836},
    '{15'sd1421, -15'sd5789, 15'sd4071, 15'sd5279, -15'sd7658, 15'sd3383,
      15'sd1514, -15'sd2614, 15'sd6038},
    '{-15'sd1033, -15'sd3475, -15'sd3007, -15'sd6456, -15'sd7356, -15'sd2724,
      -15'sd4405, -15'sd3177, -15'sd747},
    '{-15'sd2141, 15'sd2644, -15'sd585, 15'sd5642, 15'sd1582, -15'sd3274,
      15'sd4031, 15'sd689, -15'sd5236},
    '{15'sd2561, -15'sd5403, 15'sd7253, 15'sd1078, -15'sd6989, 15'sd6109,
      15'sd5541, -15'sd2099, 15'sd1312}
  };

  // Power of ten that lifts each mantissa to units of 1e-16
  localparam logic [3:0] EXP [9][9] = '{
    '{4'd14, 4'd10, 4'd10, 4'd7, 4'd6, 4'd6, 4'd2, 4'd3, 4'd1},
    '{4'd13, 4'd9,  4'd10, 4'd7, 4'd6, 4'd7, 4'd2, 4'd3, 4'd1},
    '{4'd14, 4'd10, 4'd10, 4'd6, 4'd6, 4'd6, 4'd1, 4'd2, 4'd3},
    '{4'd13, 4'd9,  4'd9,  4'd6, 4'd6, 4'd5, 4'd3, 4'd1, 4'd1},
    '{4'd13, 4'd10, 4'd10, 4'd6, 4'd6, 4'd6, 4'd2, 4'd2, 4'd1},
    '{4'd14, 4'd10, 4'd10, 4'd6, 4'd6, 4'd6, 4'd2, 4'd2, 4'd1},
    '{4'd14, 4'd10, 4'd10, 4'd6, 4'd6, 4'd6, 4'd2, 4'd2, 4'd2},
    '{4'd13, 4'd10, 4'd10, 4'd6, 4'd6, 4'd5, 4'd2, 4'd1, 4'd0},
    '{4'd14, 4'd10, 4'd10, 4'd7, 4'd6, 4'd6, 4'd2, 4'd2, 4'd2}
  };

endpackage

>>> hw/rtl/hrfc_sqrt.sv
// Pipelined integer square root, one root bit per stage, with remainder.
// Standalone; used by hrfc_lane.
module hrfc_sqrt #(
  parameter int IN_W = 48
) (
  input  logic              clk,
  input  logic              en,
  input  logic [IN_W-1:0]   din,
  output logic [IN_W/2-1:0] root,
  output logic [IN_W/2:0]   rem
);

  localparam int RW = IN_W / 2;

  logic [IN_W-1:0] v     [RW];
  logic [IN_W-1:0] r     [RW];
  logic [IN_W-1:0] v_in  [RW];
  logic [IN_W-1:0] r_in  [RW];
  logic [IN_W-1:0] v_next[RW];
  logic [IN_W-1:0] r_next[RW];
  logic [IN_W-1:0] bitc  [RW];
  logic [IN_W-1:0] trial [RW];

  // Try one root bit per stage
  always_comb begin
    for (int j = 0; j < RW; j++) begin
      if (j == 0) begin
        v_in[j] = din;
        r_in[j] = '0;
      end else begin
        v_in[j] = v[j-1];
        r_in[j] = r[j-1];
      end
      bitc[j]  = IN_W'(1) << (2 * (RW - 1 - j));
      trial[j] = r_in[j] + bitc[j];
      if (v_in[j] >= trial[j]) begin
        v_next[j] = v_in[j] - trial[j];
        r_next[j] = (r_in[j] >> 1) + bitc[j];
      end else begin
        v_next[j] = v_in[j];
        r_next[j] = r_in[j] >> 1;
      end
    end
  end

  // Advance the stages
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < RW; j++) begin
        v[j] <= v_next[j];
        r[j] <= r_next[j];
      end
    end
  end

  assign root = r[RW-1][RW-1:0];
  assign rem  = v[RW-1][RW:0];

endmodule

>>> hw/rtl/hrfc_poly.sv
// Cubic calibration polynomial: exact fixed-point sum, rounding divide, saturation.
// Depends on hrfc_pkg for coefficient tables and widths.
module hrfc_poly import hrfc_pkg::*; #(
  parameter int FRAC_BITS = 8,
  parameter int ROW       = 0
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [W_W-1:0]     w [N_TERM],
  output logic signed [FORCE_W-1:0] f
);

  localparam int NW = ACC_W + FRAC_BITS + 1;
  localparam int MW = NW - DIV_SHIFT;

  logic signed [HP_W-1:0]  ma  [N_TERM];
  logic signed [HP_W-1:0]  wl  [N_TERM];
  logic signed [HP_W-1:0]  wh  [N_TERM];
  logic signed [HP_W-1:0]  plo [N_TERM];
  logic signed [HP_W-1:0]  phi [N_TERM];
  logic signed [P_W-1:0]   p   [N_TERM];
  logic signed [P_W-1:0]   pq  [HORNER_N][N_TERM];
  logic signed [P_W-1:0]   tin [HORNER_N][N_TERM];
  logic signed [ACC_W-1:0] acc     [HORNER_N];
  logic signed [ACC_W-1:0] acc_in  [HORNER_N];
  logic signed [ACC_W-1:0] acc_next[HORNER_N];

  logic              neg_a;
  logic [ACC_W-1:0]  mag;
  logic [NW-1:0]     nval;
  logic [MW-1:0]     mval;
  logic              neg_b;
  logic              sat_b;
  logic [REM_W-1:0]  rem_b;

  logic [MH_W-1:0]   mh;
  logic [QP_W-1:0]   qe_prod;
  logic [Q_W-1:0]    qe;
  logic [Q_W-1:0]    qe2;
  logic [Q_W-1:0]    dq3;
  logic [Q_W-1:0]    qf;
  logic [REM_W-1:0]  m1;
  logic [REM_W-1:0]  m2;
  logic [REM_W-1:0]  qdp;
  logic [REM_W-1:0]  rd;
  logic              dsat     [DIV_N];
  logic              dneg     [DIV_N];

  // Split each monomial into halves for narrow constant products
  always_comb begin
    for (int i = 0; i < N_TERM; i++) begin
      ma[i] = HP_W'(MANT[ROW][i]);
      wl[i] = HP_W'($signed({1'b0, w[i][LO_W-1:0]}));
      wh[i] = HP_W'($signed(w[i][W_W-1:LO_W]));
    end
  end

  // Horner over powers of ten: acc = acc * 10 + terms of this power
  always_comb begin
    for (int h = 0; h < HORNER_N; h++) begin
      if (h == 0) acc_in[h] = '0;
      else        acc_in[h] = acc[h-1];
      acc_next[h] = (acc_in[h] <<< 3) + (acc_in[h] <<< 1);
      for (int i = 0; i < N_TERM; i++) begin
        if (h == 0) tin[h][i] = p[i];
        else        tin[h][i] = pq[h-1][i];
        if (int'(EXP[ROW][i]) == HORNER_N - 1 - h) begin
          acc_next[h] = acc_next[h] + ACC_W'(tin[h][i]);
        end
      end
    end
  end

  // Scale, add half the divisor, drop the power-of-two part of the divisor
  assign nval = (NW'(mag) << FRAC_BITS) + NW'(DIV_HALF);
  assign mval = nval[NW-1:DIV_SHIFT];

  // Quotient estimate from the top dividend bits
  assign mh = rem_b[REM_W-1:MH_LO];
  assign qe = qe_prod[RCP_SHIFT +: Q_W];

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N_TERM; i++) begin
        plo[i] <= ma[i] * wl[i];
        phi[i] <= ma[i] * wh[i];
        p[i]   <= (P_W'(phi[i]) <<< LO_W) + P_W'(plo[i]);
      end
      for (int h = 0; h < HORNER_N; h++) begin
        acc[h] <= acc_next[h];
        for (int i = 0; i < N_TERM; i++) begin
          pq[h][i] <= tin[h][i];
        end
      end
      neg_a <= acc[HORNER_N-1][ACC_W-1];
      mag   <= acc[HORNER_N-1][ACC_W-1] ? ACC_W'(-acc[HORNER_N-1])
                                        : ACC_W'(acc[HORNER_N-1]);
      neg_b <= neg_a;
      sat_b <= neg_a ? (mval >= MW'(SAT_NEG)) : (mval >= MW'(SAT_POS));
      rem_b <= mval[REM_W-1:0];

      // Divide by 5^16: estimate, multiply back, correct by one
      qe_prod <= QP_W'(mh) * QP_W'(RCP);
      m1      <= rem_b;
      qdp     <= REM_W'(qe) * REM_W'(DIV5);
      qe2     <= qe;
      m2      <= m1;
      rd      <= m2 - qdp;
      dq3     <= qe2;
      qf      <= (rd >= REM_W'(DIV5)) ? (dq3 + 1'b1) : dq3;
      for (int j = 0; j < DIV_N; j++) begin
        if (j == 0) begin
          dsat[j] <= sat_b;
          dneg[j] <= neg_b;
        end else begin
          dsat[j] <= dsat[j-1];
          dneg[j] <= dneg[j-1];
        end
      end
      if (dsat[DIV_N-1]) f <= dneg[DIV_N-1] ? FORCE_MIN : FORCE_MAX;
      else               f <= dneg[DIV_N-1] ? (~qf + 1'b1) : qf;
    end
  end

endmodule

>>> hw/rtl/hrfc_lane.sv
// One sensor position: monomials, radial field, three polynomials, shear magnitude.
// Depends on hrfc_pkg, hrfc_sqrt and hrfc_poly.
module hrfc_lane import hrfc_pkg::*; #(
  parameter int FRAC_BITS = 8,
  parameter int POS       = 0
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [IN_FW-1:0]   bx,
  input  logic signed [IN_FW-1:0]   by,
  input  logic signed [IN_FW-1:0]   bz,
  output logic signed [FORCE_W-1:0] fx,
  output logic signed [FORCE_W-1:0] fy,
  output logic signed [FORCE_W-1:0] fz,
  output logic [FR_W-1:0]           fr
);

  localparam int XD = R_RW;
  localparam int FD = F_RW + 3;

  // Radial path
  logic signed [33:0] bxe, bye;
  logic signed [33:0] xx1, yy1;
  logic [33:0]        sq2;
  logic [R_RW-1:0]    r8;

  // Field delay while the radial root is formed
  logic signed [IN_FW-1:0] xd [XD];
  logic signed [IN_FW-1:0] yd [XD];
  logic signed [IN_FW-1:0] zd [XD];

  logic signed [33:0] xe, ye, ze;
  logic signed [IN_FW-1:0] xa, ya, za, xb, yb, zb, xc, yc, zc;
  logic signed [33:0] xxa, yya, zza, xza, yza;
  logic signed [33:0] xxb, yyb, zzb, xzb, yzb;
  logic signed [33:0] xxc, yyc, zzc, xzc, yzc;
  logic signed [50:0] xxzb, xzzb, yyzb, yzzb, zzzb;
  logic signed [50:0] xxzc, xzzc, yyzc, yzzc, zzzc;
  logic [33:0]        sqb, sqc;
  logic signed [50:0] sqzc;
  logic [R_RW-1:0]    r8c;
  logic signed [42:0] r8zc;
  logic signed [W_W-1:0] r8zzc;

  logic signed [W_W-1:0] wx [N_TERM];
  logic signed [W_W-1:0] wy [N_TERM];
  logic signed [W_W-1:0] wz [N_TERM];

  logic signed [FORCE_W-1:0] fxp, fyp, fzp;
  logic signed [47:0]        fxe, fye;
  logic signed [47:0]        fxx, fyy;
  logic [F_IN_W-1:0]         fsum;
  logic [F_RW-1:0]           froot;
  logic [F_RW:0]             frem;
  logic [F_RW:0]             frnd;
  logic signed [FORCE_W-1:0] fxd [FD];
  logic signed [FORCE_W-1:0] fyd [FD];
  logic signed [FORCE_W-1:0] fzd [FD];

  assign bxe = 34'(bx);
  assign bye = 34'(by);
  assign xe  = 34'(xd[XD-1]);
  assign ye  = 34'(yd[XD-1]);
  assign ze  = 34'(zd[XD-1]);

  hrfc_sqrt #(.IN_W(R_IN_W)) u_rsqrt (
    .clk  (clk),
    .en   (en),
    .din  ({sq2, 16'b0}),
    .root (r8),
    .rem  ()
  );

  // Monomial stages
  always_ff @(posedge clk) begin
    if (en) begin
      xx1 <= bxe * bxe;
      yy1 <= bye * bye;
      sq2 <= xx1[33:0] + yy1[33:0];

      xd[0] <= bx;
      yd[0] <= by;
      zd[0] <= bz;
      for (int k = 1; k < XD; k++) begin
        xd[k] <= xd[k-1];
        yd[k] <= yd[k-1];
        zd[k] <= zd[k-1];
      end

      xa  <= xd[XD-1];
      ya  <= yd[XD-1];
      za  <= zd[XD-1];
      xxa <= xe * xe;
      yya <= ye * ye;
      zza <= ze * ze;
      xza <= xe * ze;
      yza <= ye * ze;

      xb   <= xa;
      yb   <= ya;
      zb   <= za;
      xxb  <= xxa;
      yyb  <= yya;
      zzb  <= zza;
      xzb  <= xza;
      yzb  <= yza;
      xxzb <= 51'(xxa) * 51'(za);
      xzzb <= 51'(xa) * 51'(zza);
      yyzb <= 51'(yya) * 51'(za);
      yzzb <= 51'(ya) * 51'(zza);
      zzzb <= 51'(zza) * 51'(za);
      sqb  <= xxa[33:0] + yya[33:0];

      xc    <= xb;
      yc    <= yb;
      zc    <= zb;
      xxc   <= xxb;
      yyc   <= yyb;
      zzc   <= zzb;
      xzc   <= xzb;
      yzc   <= yzb;
      xxzc  <= xxzb;
      xzzc  <= xzzb;
      yyzc  <= yyzb;
      yzzc  <= yzzb;
      zzzc  <= zzzb;
      sqc   <= sqb;
      sqzc  <= 51'($signed({1'b0, sqb})) * 51'(zb);
      r8c   <= r8;
      r8zc  <= 43'($signed({1'b0, r8})) * 43'(zb);
      r8zzc <= W_W'($signed({1'b0, r8})) * W_W'(zzb);
    end
  end

  // Monomial vectors in units of 2^-8
  always_comb begin
    wx[0] = W_ONE;
    wx[1] = W_W'(xc) <<< 8;
    wx[2] = W_W'(zc) <<< 8;
    wx[3] = W_W'(xxc) <<< 8;
    wx[4] = W_W'(xzc) <<< 8;
    wx[5] = W_W'(zzc) <<< 8;
    wx[6] = W_W'(xxzc) <<< 8;
    wx[7] = W_W'(xzzc) <<< 8;
    wx[8] = W_W'(zzzc) <<< 8;

    wy[0] = W_ONE;
    wy[1] = W_W'(yc) <<< 8;
    wy[2] = W_W'(zc) <<< 8;
    wy[3] = W_W'(yyc) <<< 8;
    wy[4] = W_W'(yzc) <<< 8;
    wy[5] = W_W'(zzc) <<< 8;
    wy[6] = W_W'(yyzc) <<< 8;
    wy[7] = W_W'(yzzc) <<< 8;
    wy[8] = W_W'(zzzc) <<< 8;

    wz[0] = W_ONE;
    wz[1] = W_W'($signed({1'b0, r8c}));
    wz[2] = W_W'(zc) <<< 8;
    wz[3] = W_W'($signed({1'b0, sqc})) <<< 8;
    wz[4] = W_W'(r8zc);
    wz[5] = W_W'(zzc) <<< 8;
    wz[6] = W_W'(sqzc) <<< 8;
    wz[7] = r8zzc;
    wz[8] = W_W'(zzzc) <<< 8;
  end

  hrfc_poly #(.FRAC_BITS(FRAC_BITS), .ROW(3 * POS)) u_px (
    .clk (clk), .en (en), .w (wx), .f (fxp)
  );

  hrfc_poly #(.FRAC_BITS(FRAC_BITS), .ROW(3 * POS + 1)) u_py (
    .clk (clk), .en (en), .w (wy), .f (fyp)
  );

  hrfc_poly #(.FRAC_BITS(FRAC_BITS), .ROW(3 * POS + 2)) u_pz (
    .clk (clk), .en (en), .w (wz), .f (fzp)
  );

  assign fxe = 48'(fxp);
  assign fye = 48'(fyp);

  hrfc_sqrt #(.IN_W(F_IN_W)) u_fsqrt (
    .clk  (clk),
    .en   (en),
    .din  (fsum),
    .root (froot),
    .rem  (frem)
  );

  // Round the root to nearest
  assign frnd = (frem > {1'b0, froot}) ? ({1'b0, froot} + 1'b1) : {1'b0, froot};

  // Shear magnitude and force delay
  always_ff @(posedge clk) begin
    if (en) begin
      fxx  <= fxe * fxe;
      fyy  <= fye * fye;
      fsum <= fxx[F_IN_W-1:0] + fyy[F_IN_W-1:0];

      fxd[0] <= fxp;
      fyd[0] <= fyp;
      fzd[0] <= fzp;
      for (int k = 1; k < FD; k++) begin
        fxd[k] <= fxd[k-1];
        fyd[k] <= fyd[k-1];
        fzd[k] <= fzd[k-1];
      end

      fr <= (frnd > (F_RW + 1)'(FR_MAX)) ? FR_MAX : frnd[FR_W-1:0];
    end
  end

  assign fx = fxd[FD-1];
  assign fy = fyd[FD-1];
  assign fz = fzd[FD-1];

endmodule

>>> hw/rtl/hall_row_force_calibration.sv
// Top level: three position lanes on one stream pipeline with a shared valid line.
// Depends on hrfc_pkg and hrfc_lane.
//
//  channel   dir  width  content
//  s_*       in   160    one sensor row: nine 17-bit fields
//  m_*       out  288    forces and shear magnitudes for three positions
//
// One row enters per cycle unless the output is held; each row passes
// LANE_LAT (79) pipeline stages on its way to m_*. The depth is set mostly by
// the radial and shear root units (one bit per stage) and the 15-step Horner sum.
// Reset clears the valid line only; data registers are not reset.
// A held output stalls every stage at once, and input ready follows it.
module hall_row_force_calibration import hrfc_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // top_bx, top_by, top_bz, mid_bx, mid_by, mid_bz, bot_bx, bot_by, bot_bz, pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // top_fx, top_fy, top_fz, top_fr, mid_fx, mid_fy, mid_fz, mid_fr,
  // bot_fx, bot_fy, bot_fz, bot_fr, pad
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  logic                      en;
  logic [LANE_LAT-1:0]       vld;
  logic signed [FORCE_W-1:0] fx [N_POS];
  logic signed [FORCE_W-1:0] fy [N_POS];
  logic signed [FORCE_W-1:0] fz [N_POS];
  logic [FR_W-1:0]           fr [N_POS];

  // Advance whenever the output slot is free or being taken
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LANE_LAT-1];

  // Track valid rows through the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LANE_LAT-2:0], s_tvalid};
    end
  end

  for (genvar p = 0; p < N_POS; p++) begin : g_lane
    hrfc_lane #(.FRAC_BITS(FRAC_BITS), .POS(p)) u_lane (
      .clk (clk),
      .en  (en),
      .bx  ($signed(s_tdata[p*POS_IN_W +: IN_FW])),
      .by  ($signed(s_tdata[p*POS_IN_W + IN_FW +: IN_FW])),
      .bz  ($signed(s_tdata[p*POS_IN_W + 2*IN_FW +: IN_FW])),
      .fx  (fx[p]),
      .fy  (fy[p]),
      .fz  (fz[p]),
      .fr  (fr[p])
    );
  end

  // Pack the result transfer
  always_comb begin
    m_tdata = '0;
    for (int p = 0; p < N_POS; p++) begin
      m_tdata[p*POS_OUT_W +: FORCE_W]             = fx[p];
      m_tdata[p*POS_OUT_W + FORCE_W +: FORCE_W]   = fy[p];
      m_tdata[p*POS_OUT_W + 2*FORCE_W +: FORCE_W] = fz[p];
      m_tdata[p*POS_OUT_W + 3*FORCE_W +: FR_W]    = fr[p];
    end
  end

endmodule

>>> verif/hall_row_force_calibration_test.sv
// Self-checking testbench for the hall row force calibration stream block.
// Depends on hrfc_pkg (port widths) and hall_row_force_calibration (DUT).
module hall_row_force_calibration_test;
  import hrfc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  FRAC       = 8;
  localparam int  CYCLE_CAP  = 400000;
  localparam int  TAIL_WAIT  = 150;
  localparam int  RAND_ROWS  = 580;
  localparam int  ROW_BITS   = 9 * IN_FW;
  localparam longint F_POS   = 8388607;
  localparam longint F_NEG   = 8388608;
  localparam logic [127:0] DIVR = 128'd2560000000000000000;

  // Force calibration scoreboard: computes forces for each accepted row and
  // checks them against the rows leaving the block in order.
  class force_scoreboard;
    logic [OUT_TDATA_W-1:0] forces_due[$];
    int errors;
    int mant [9][9];
    int dec [9][9];

    function new();
      mant = '{
        '{1333, -3288, 3361, 724, -6201, 2654, 4886, -242, 6595},
        '{2824, -4832, 1006, 521, -3988, 135, 3199, -218, 4829},
        '{2447, -4608, 6606, 3998, -6645, 5293, 6865, -2459, 106},
        '{1411, -2827, 3494, 1662, -1945, 3569, 112, -9128, 1119},
        '{7812, -4493, 2601, -1078, -7358, 2632, -1189, -2614, 7836},
        '{1421, -5789, 4071, 5279, -7658, 3383, 1514, -2614, 6038},
        '{-1033, -3475, -3007, -6456, -7356, -2724, -4405, -3177, -747},
        '{-2141, 2644, -585, 5642, 1582, -3274, 4031, 689, -5236},
        '{2561, -5403, 7253, 1078, -6989, 6109, 5541, -2099, 1312}};
      dec = '{
        '{2, 6, 6, 9, 10, 10, 14, 13, 15},
        '{3, 7, 6, 9, 10, 9, 14, 13, 15},
        '{2, 6, 6, 10, 10, 10, 15, 14, 13},
        '{3, 7, 7, 10, 10, 11, 13, 15, 15},
        '{3, 6, 6, 10, 10, 10, 14, 14, 15},
        '{2, 6, 6, 10, 10, 10, 14, 14, 15},
        '{2, 6, 6, 10, 10, 10, 14, 14, 14},
        '{3, 6, 6, 10, 10, 11, 14, 15, 16},
        '{2, 6, 6, 9, 10, 10, 14, 14, 14}};
      errors = 0;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // Exact sum in 1e-16 * 2^-8 units, one rounding, then saturation
    function longint calib_force(int row, longint mono [9]);
      logic signed [127:0] acc, kk, mm;
      logic [127:0] mag, q;
      longint k;
      bit neg;
      acc = 0;
      for (int i = 0; i < 9; i++) begin
        k = mant[row][i];
        repeat ((16 - dec[row][i]) & 15) k *= 10;
        kk = k;
        mm = mono[i];
        acc += kk * mm;
      end
      neg = acc[127];
      mag = neg ? -acc : acc;
      mag = mag << FRAC;
      mag = mag + DIVR / 2;
      q = mag / DIVR;
      if (neg) return (q > F_NEG) ? -F_NEG : -longint'(q);
      return (q > F_POS) ? F_POS : longint'(q);
    endfunction

    function void plain_terms(output longint m [9], input longint a, input longint z);
      m[0] = 256;       m[1] = a * 256;       m[2] = z * 256;
      m[3] = a * a * 256; m[4] = a * z * 256; m[5] = z * z * 256;
      m[6] = a * a * z * 256; m[7] = a * z * z * 256; m[8] = z * z * z * 256;
    endfunction

    // Predict the forces for one accepted row
    function void note_row(logic [ROW_BITS-1:0] row);
      logic [OUT_TDATA_W-1:0] res;
      longint x, y, z, fx, fy, fz, sq, r8;
      longint m [9];
      longint unsigned sum, fr, rem;
      res = '0;
      for (int p = 0; p < 3; p++) begin
        x = longint'($signed(row[(3*p)*IN_FW +: IN_FW]));
        y = longint'($signed(row[(3*p+1)*IN_FW +: IN_FW]));
        z = longint'($signed(row[(3*p+2)*IN_FW +: IN_FW]));
        plain_terms(m, x, z);
        fx = calib_force(3*p, m);
        plain_terms(m, y, z);
        fy = calib_force(3*p+1, m);
        sq = x * x + y * y;
        r8 = longint'(int_sqrt(longint'(sq) << 16));
        m[1] = r8; m[3] = sq * 256; m[4] = r8 * z;
        m[6] = sq * z * 256; m[7] = r8 * z * z;
        fz = calib_force(3*p+2, m);
        sum = fx * fx + fy * fy;
        fr = int_sqrt(sum);
        rem = sum - fr * fr;
        if (rem > fr) fr++;
        if (fr > F_POS) fr = F_POS;
        res[p*POS_OUT_W +: 24]      = fx[23:0];
        res[p*POS_OUT_W + 24 +: 24] = fy[23:0];
        res[p*POS_OUT_W + 48 +: 24] = fz[23:0];
        res[p*POS_OUT_W + 72 +: 23] = fr[22:0];
      end
      forces_due.push_back(res);
    endfunction

    task report(string what);
      $display("MISMATCH: %s", what);
      errors++;
    endtask

    // Compare a delivered row field by field with the oldest prediction
    task check_row(logic [OUT_TDATA_W-1:0] got);
      logic [OUT_TDATA_W-1:0] want;
      int lo, w;
      if (forces_due.size() == 0) begin
        report($sformatf("unexpected output row %h", got));
        return;
      end
      want = forces_due.pop_front();
      for (int f = 0; f < 12; f++) begin
        lo = (f / 4) * POS_OUT_W + (f % 4) * 24;
        w = (f % 4 == 3) ? 23 : 24;
        if (((got >> lo) & ((288'd1 << w) - 1)) != ((want >> lo) & ((288'd1 << w) - 1)))
          report($sformatf("field %0d: got %h want %h", f,
                 (got >> lo) & ((288'd1 << w) - 1), (want >> lo) & ((288'd1 << w) - 1)));
      end
    endtask

    function int pending();
      return forces_due.size();
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  force_scoreboard sb = new();
  bit tx_gaps = 1;
  bit rx_gaps = 1;
  int hold_req = 0;
  int cycles = 0;

  hall_row_force_calibration DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #4 clk = ~clk;

  // Abort on a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("hall_row_force_calibration test failed");
      $finish;
    end
  end

  // Check every output transfer
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_row(m_tdata);
  end

  // Drive output ready: long hold-offs on request, random stall bursts
  initial begin
    int stall_left;
    bit rdy;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (rst) begin
        rdy = 0;
      end else if (hold_req > 0) begin
        hold_req--;
        rdy = 0;
      end else begin
        if (rx_gaps && stall_left == 0 && $urandom_range(0, 7) == 0)
          stall_left = $urandom_range(1, 17);
        if (rx_gaps && stall_left > 0) begin
          stall_left--;
          rdy = 0;
        end else begin
          rdy = 1;
        end
      end
      m_tready <= rdy;
    end
  end

  // Offer one row and hold it until the transfer
  task send_row(logic [ROW_BITS-1:0] row);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= IN_TDATA_W'(row);
    do @(posedge clk); while (!s_tready);
    sb.note_row(row);
    @(negedge clk);
  endtask

  function logic [IN_FW-1:0] pick_field();
    case ($urandom_range(0, 3))
      0: return IN_FW'($urandom);
      1: return IN_FW'(int'($urandom_range(0, 8000)) - 4000);
      2: return IN_FW'(int'($urandom_range(0, 600)) - 300);
      default: return IN_FW'(int'($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  task send_random(int n);
    logic [ROW_BITS-1:0] row;
    for (int i = 0; i < n; i++) begin
      for (int f = 0; f < 9; f++) row[f*IN_FW +: IN_FW] = pick_field();
      send_row(row);
    end
  endtask

  initial begin
    logic [ROW_BITS-1:0] row;
    logic [IN_FW-1:0] ext [4];
    ext = '{17'h00000, 17'h0FFFF, 17'h10000, 17'h1FFFF};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed rows: every field at each extreme, then mixed extremes
    for (int e = 0; e < 4; e++) begin
      for (int f = 0; f < 9; f++) row[f*IN_FW +: IN_FW] = ext[e];
      send_row(row);
    end
    for (int i = 0; i < 16; i++) begin
      for (int f = 0; f < 9; f++) row[f*IN_FW +: IN_FW] = ext[(i + f * (i / 4 + 1)) % 4];
      send_row(row);
    end

    send_random(150);

    // Hold output off long enough to back the pipeline up
    hold_req = 400;
    tx_gaps = 0;
    send_random(150);
    tx_gaps = 1;

    // Pause until the pipeline drains
    s_tvalid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
    send_random(RAND_ROWS - 380);

    // Final stretch at full rate on both sides
    tx_gaps = 0;
    rx_gaps = 0;
    send_random(80);
    s_tvalid <= 0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("hall_row_force_calibration test passed");
    end else begin
      $display("hall_row_force_calibration test failed");
    end
    $finish;
  end
endmodule

>>> filelist.f
hw/rtl/hrfc_pkg.sv
hw/rtl/hrfc_sqrt.sv
hw/rtl/hrfc_poly.sv
hw/rtl/hrfc_lane.sv
hw/rtl/hall_row_force_calibration.sv
verif/hall_row_force_calibration_test.sv
